// ----- design/sm4_pkg.sv -----
// SM4 shared types, constants and round functions.
`default_nettype none
package sm4_pkg;

	localparam int Rounds = 32;
	localparam int RkAw = 5;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_LOW = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_DECRYPT = 2'd2;

	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;

	localparam logic [7:0] SBOX [0:255] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef struct packed {
		logic             expand;
		logic             rd_en;
		logic [RkAw-1:0]  rd_addr;
	} ks_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ks_rsp_t;

	function automatic logic [31:0] tau(input logic [31:0] a);
		return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [31:0] lin_round(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
			{b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	function automatic logic [31:0] ck_word(input logic [RkAw-1:0] i);
		logic [31:0] w;
		logic [7:0]  c;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			c = ({1'b0, i, 2'b00} + 8'(j)) * 8'd7;
			w = {w[23:0], c};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- design/sm4_key_sched.sv -----
// SM4 key expansion and round-key memory.
`default_nettype none
module sm4_key_sched (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [63:0]      key_high,
	input  wire logic [63:0]      key_low,
	input  wire sm4_pkg::ks_req_t req,
	output sm4_pkg::ks_rsp_t      rsp,
	output logic [31:0]           rk
);

	typedef enum logic {KS_IDLE, KS_RUN} ks_state_t;

	ks_state_t                 state_q;
	logic [sm4_pkg::RkAw-1:0]  cnt_q;
	logic [31:0]               k0_q, k1_q, k2_q, k3_q;
	logic                      done_q;
	logic [31:0]               nk;
	logic [31:0]               mem [0:sm4_pkg::Rounds-1];

	assign nk = k0_q ^ sm4_pkg::lin_key(sm4_pkg::tau(k1_q ^ k2_q ^ k3_q ^
		sm4_pkg::ck_word(cnt_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				KS_IDLE: begin
					if (req.expand) begin
						state_q <= KS_RUN;
						cnt_q <= '0;
					end
				end
				KS_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sm4_pkg::RkAw'(sm4_pkg::Rounds - 1)) begin
						state_q <= KS_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= KS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == KS_IDLE && req.expand) begin
			k0_q <= key_high[63:32] ^ sm4_pkg::FK0;
			k1_q <= key_high[31:0] ^ sm4_pkg::FK1;
			k2_q <= key_low[63:32] ^ sm4_pkg::FK2;
			k3_q <= key_low[31:0] ^ sm4_pkg::FK3;
		end else if (state_q == KS_RUN) begin
			k0_q <= k1_q;
			k1_q <= k2_q;
			k2_q <= k3_q;
			k3_q <= nk;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == KS_RUN)
			mem[cnt_q] <= nk;
		if (req.rd_en)
			rk <= mem[req.rd_addr];
	end

	assign rsp.busy = (state_q == KS_RUN);
	assign rsp.done = done_q;

endmodule
`default_nettype wire

// ----- design/sm4_block_cipher_core.sv -----
// SM4 block cipher core: configuration, round sequencer and data path.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  config   | cfg_write_en               | cfg_index, cfg_data
//  input    | start (taken when !busy)   | block_high, block_low
//  result   | done (one-cycle strobe)    | result_high, result_low
//
// A block runs one round per cycle from acceptance to the done strobe, limited by the
// single read port of the round-key memory.
// The first block after a key write first expands the keys, then hands over and primes
// the memory read (state ST_PRIME) before its rounds begin.
// Reset clears the key, the direction and the keys-ready flag.
// The next block may start in the cycle that done is high.
`default_nettype none
module sm4_block_cipher_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [sm4_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [63:0]                  cfg_data,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [63:0]                  block_high,
	input  wire logic [63:0]                  block_low,
	output logic                              done,
	output logic [63:0]                       result_high,
	output logic [63:0]                       result_low
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_PRIME, ST_ROUND} state_t;

	state_t                    state_q;
	logic [63:0]               key_high_q, key_low_q;
	logic                      decrypt_q;
	logic                      keys_ready_q;
	logic [sm4_pkg::RkAw-1:0]  rnd_q;
	logic [31:0]               x0_q, x1_q, x2_q, x3_q;
	logic                      done_q;
	logic [63:0]               res_high_q, res_low_q;

	logic                      accept;
	logic [sm4_pkg::RkAw-1:0]  rd_round;
	logic [31:0]               rk;
	logic [31:0]               nx;
	sm4_pkg::ks_req_t          ks_req;
	sm4_pkg::ks_rsp_t          ks_rsp;

	assign accept = start && !busy;
	assign rd_round = (state_q == ST_ROUND) ? rnd_q + 1'b1 : '0;

	always_comb begin
		ks_req.expand = accept && !keys_ready_q;
		ks_req.rd_en = (accept && keys_ready_q) || state_q == ST_PRIME || state_q == ST_ROUND;
		ks_req.rd_addr = decrypt_q ? ~rd_round : rd_round;
	end

	sm4_key_sched u_key_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_high (key_high_q),
		.key_low  (key_low_q),
		.req      (ks_req),
		.rsp      (ks_rsp),
		.rk       (rk)
	);

	assign nx = x0_q ^ sm4_pkg::lin_round(sm4_pkg::tau(x1_q ^ x2_q ^ x3_q ^ rk));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				sm4_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				sm4_pkg::CFG_KEY_LOW: key_low_q <= cfg_data;
				sm4_pkg::CFG_DECRYPT: decrypt_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keys_ready_q <= 1'b0;
			rnd_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write_en && (cfg_index == sm4_pkg::CFG_KEY_HIGH ||
					cfg_index == sm4_pkg::CFG_KEY_LOW))
				keys_ready_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rnd_q <= '0;
						state_q <= keys_ready_q ? ST_ROUND : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (ks_rsp.done) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == sm4_pkg::RkAw'(sm4_pkg::Rounds - 1)) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q <= block_high[63:32];
			x1_q <= block_high[31:0];
			x2_q <= block_low[63:32];
			x3_q <= block_low[31:0];
		end else if (state_q == ST_ROUND) begin
			x0_q <= x1_q;
			x1_q <= x2_q;
			x2_q <= x3_q;
			x3_q <= nx;
		end
		if (state_q == ST_ROUND && rnd_q == sm4_pkg::RkAw'(sm4_pkg::Rounds - 1)) begin
			res_high_q <= {nx, x3_q};
			res_low_q <= {x2_q, x1_q};
		end
	end

	assign busy = (state_q != ST_IDLE) || ks_rsp.busy;
	assign done = done_q;
	assign result_high = res_high_q;
	assign result_low = res_low_q;

endmodule
`default_nettype wire
